### src/pef_pkg.sv
`timescale 1ns / 1ps
package pef_pkg;

  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_LOAD  = 2'd1;
  localparam logic [1:0] FN_TEST  = 2'd2;
  localparam logic [1:0] FN_SPARE = 2'd3;

  localparam logic [1:0] REG_USE_DERIVED = 2'd0;
  localparam logic [1:0] REG_FLAT_RADIUS = 2'd1;
  localparam logic [1:0] REG_RADIUS_MULT = 2'd2;

  localparam logic [15:0] MULT_RESET = 16'd256;
  localparam logic [55:0] R2_SAT     = {56{1'b1}};

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        tag;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [23:0]        extent_x;
    logic [23:0]        extent_y;
    logic [23:0]        extent_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } in_t;

  typedef struct packed {
    logic [15:0]        out_tag;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
  } out_t;

  // one stored suppressor
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [23:0]        ex;
    logic [23:0]        ey;
    logic [23:0]        ez;
    logic [15:0]        max_scale;
  } sup_t;

  // pipeline token: act marks a sweep step, ent a stored entry, last the final step
  typedef struct packed {
    logic act;
    logic ent;
    logic last;
  } tok_t;

endpackage

### src/pef_cell.sv
`timescale 1ns / 1ps
module pef_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  logic          load_en,
  input  pef_pkg::sup_t load_d,
  input  pef_pkg::sup_t nbr_d,
  output pef_pkg::sup_t q
);

  pef_pkg::sup_t data_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      data_r <= load_d;
    end else if (shift_en) begin
      data_r <= nbr_d;
    end
  end

  assign q = data_r;

endmodule

### src/pef_eval.sv
`timescale 1ns / 1ps
module pef_eval (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [23:0] cand_x,
  input  logic signed [23:0] cand_y,
  input  logic signed [23:0] cand_z,
  input  pef_pkg::sup_t      head,
  input  pef_pkg::tok_t      tok_in,
  input  logic               use_derived,
  input  logic [15:0]        mult,
  input  logic [47:0]        flat2,
  output logic               hit,
  output pef_pkg::tok_t      tok_out
);

  function automatic logic [23:0] abs_diff(input logic signed [23:0] a,
                                           input logic signed [23:0] b);
    logic signed [24:0] d;
    logic [24:0]        n;
    d = {a[23], a} - {b[23], b};
    n = d[24] ? (~d + 25'd1) : d;
    return n[23:0];
  endfunction

  pef_pkg::tok_t tok1_r, tok2_r, tok3_r, tok4_r, tok5_r, tok6_r;

  // stage 1: deltas and scale product
  logic [23:0] dx1_r, dy1_r, dz1_r, ex1_r, ey1_r, ez1_r;
  logic [31:0] sm1_r;
  // stage 2: squares
  logic [47:0] dx2_r, dy2_r, dz2_r, ex2_r, ey2_r, ez2_r;
  logic [63:0] sm2_r;
  // stage 3: sums
  logic [49:0] d2_3_r, diag3_r;
  logic [63:0] sm3_r;
  // stage 4: partial products of diag * sm^2
  logic [56:0] p00_r, p01_r, p10_r, p11_r;
  logic [49:0] d2_4_r;
  // stage 5: derived radius
  logic [55:0] r2d5_r;
  logic [49:0] d2_5_r;
  logic        hit_r;

  logic [113:0] prod;
  logic [79:0]  prod_q;
  logic [55:0]  r2_sel;

  always_comb begin
    prod = {57'd0, p00_r} + ({57'd0, p01_r} << 32) + ({57'd0, p10_r} << 25)
         + ({57'd0, p11_r} << 57);
    prod_q = prod[113:34];
    r2_sel = use_derived ? r2d5_r : {8'd0, flat2};
  end

  always_ff @(posedge clk) begin
    dx1_r  <= abs_diff(cand_x, head.x);
    dy1_r  <= abs_diff(cand_y, head.y);
    dz1_r  <= abs_diff(cand_z, head.z);
    ex1_r  <= head.ex;
    ey1_r  <= head.ey;
    ez1_r  <= head.ez;
    sm1_r  <= 32'(head.max_scale) * 32'(mult);

    dx2_r  <= 48'(dx1_r) * 48'(dx1_r);
    dy2_r  <= 48'(dy1_r) * 48'(dy1_r);
    dz2_r  <= 48'(dz1_r) * 48'(dz1_r);
    ex2_r  <= 48'(ex1_r) * 48'(ex1_r);
    ey2_r  <= 48'(ey1_r) * 48'(ey1_r);
    ez2_r  <= 48'(ez1_r) * 48'(ez1_r);
    sm2_r  <= 64'(sm1_r) * 64'(sm1_r);

    d2_3_r  <= {2'd0, dx2_r} + {2'd0, dy2_r} + {2'd0, dz2_r};
    diag3_r <= {2'd0, ex2_r} + {2'd0, ey2_r} + {2'd0, ez2_r};
    sm3_r   <= sm2_r;

    p00_r  <= 57'(diag3_r[24:0]) * 57'(sm3_r[31:0]);
    p01_r  <= 57'(diag3_r[24:0]) * 57'(sm3_r[63:32]);
    p10_r  <= 57'(diag3_r[49:25]) * 57'(sm3_r[31:0]);
    p11_r  <= 57'(diag3_r[49:25]) * 57'(sm3_r[63:32]);
    d2_4_r <= d2_3_r;

    r2d5_r <= (|prod_q[79:56]) ? pef_pkg::R2_SAT : prod_q[55:0];
    d2_5_r <= d2_4_r;

    hit_r  <= tok5_r.ent && (r2_sel != 56'd0) && ({6'd0, d2_5_r} <= r2_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r <= '0;
      tok2_r <= '0;
      tok3_r <= '0;
      tok4_r <= '0;
      tok5_r <= '0;
      tok6_r <= '0;
    end else begin
      tok1_r <= tok_in;
      tok2_r <= tok1_r;
      tok3_r <= tok2_r;
      tok4_r <= tok3_r;
      tok5_r <= tok4_r;
      tok6_r <= tok5_r;
    end
  end

  assign hit     = hit_r;
  assign tok_out = tok6_r;

endmodule

### src/proximity_exclusion_filter.sv
`timescale 1ns / 1ps
// proximity exclusion filter
// the input channel takes a word when start is high and busy is low. func selects
// clear (empties the suppressor table), load (stores one suppressor in the next free
// cell, ignored when all CAPACITY cells are full) or test (checks a candidate).
// clear, load and the unused code give no result and do not raise busy.
// a test rotates the ring of suppressor cells once: each cycle the head cell feeds a
// 6-stage distance/radius pipeline. a test holds busy until the last cell's result
// leaves the pipeline; a surviving candidate shows up on out_data with out_valid high
// for one cycle right after busy drops; a suppressed candidate gives nothing.
// one test runs at a time: no new word is taken until the single walk of the ring
// past the shared pipeline is done.
// the receiver cannot stall: every result is taken in the cycle it is shown.
// registers are written over the apb port (byte address 4 * index); the user must
// write them only while idle, the block does not enforce it. reset empties the table
// and loads the register reset values; stored suppressor data is not cleared.
module proximity_exclusion_filter #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pef_pkg::in_t   in_data,
  output logic           out_valid,
  output pef_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic            use_derived_r;
  logic [23:0]     flat_r;
  logic [15:0]     mult_r;
  logic [47:0]     flat2_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [IDXW-1:0] step_r, step_nxt;
  logic            acc_r, acc_nxt;
  pef_pkg::in_t    cand_r;
  logic            out_valid_r, out_valid_nxt;
  pef_pkg::out_t   out_r;

  logic            accept, load_go, shift_en;
  logic [1:0]      reg_idx;
  logic [15:0]     ax, ay, az, ms;
  pef_pkg::sup_t   load_d;
  pef_pkg::sup_t   cells [CAPACITY];
  pef_pkg::tok_t   tok_in, tok_out;
  logic            hit;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign reg_idx  = paddr[3:2];
  assign pready   = 1'b1;
  assign shift_en = (state_r == ST_SWEEP);
  assign load_go  = accept && (in_data.func == pef_pkg::FN_LOAD)
                    && (cnt_r < CNTW'(CAPACITY));

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_derived_r <= 1'b0;
      flat_r        <= '0;
      mult_r        <= pef_pkg::MULT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        pef_pkg::REG_USE_DERIVED: use_derived_r <= pwdata[0];
        pef_pkg::REG_FLAT_RADIUS: flat_r        <= pwdata[23:0];
        pef_pkg::REG_RADIUS_MULT: mult_r        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    flat2_r <= 48'(flat_r) * 48'(flat_r);
  end

  always_comb begin
    case (reg_idx)
      pef_pkg::REG_USE_DERIVED: prdata = {31'd0, use_derived_r};
      pef_pkg::REG_FLAT_RADIUS: prdata = {8'd0, flat_r};
      pef_pkg::REG_RADIUS_MULT: prdata = {16'd0, mult_r};
      default:                  prdata = '0;
    endcase
  end

  // largest absolute scale
  always_comb begin
    ax = in_data.scale_x[15] ? (~in_data.scale_x + 16'd1) : in_data.scale_x;
    ay = in_data.scale_y[15] ? (~in_data.scale_y + 16'd1) : in_data.scale_y;
    az = in_data.scale_z[15] ? (~in_data.scale_z + 16'd1) : in_data.scale_z;
    ms = ax;
    if (ay > ms) ms = ay;
    if (az > ms) ms = az;
    load_d = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z,
               ex: in_data.extent_x, ey: in_data.extent_y, ez: in_data.extent_z,
               max_scale: ms};
  end

  // ring of cells, cell 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int NXT = (i + 1) % CAPACITY;
    pef_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .load_en  (load_go && (cnt_r[IDXW-1:0] == IDXW'(i))),
      .load_d   (load_d),
      .nbr_d    (cells[NXT]),
      .q        (cells[i])
    );
  end

  assign tok_in = '{act:  shift_en,
                    ent:  shift_en && (CNTW'(step_r) < cnt_r),
                    last: shift_en && (step_r == IDXW'(CAPACITY - 1))};

  pef_eval u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .cand_x      (cand_r.pos_x),
    .cand_y      (cand_r.pos_y),
    .cand_z      (cand_r.pos_z),
    .head        (cells[0]),
    .tok_in      (tok_in),
    .use_derived (use_derived_r),
    .mult        (mult_r),
    .flat2       (flat2_r),
    .hit         (hit),
    .tok_out     (tok_out)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.func)
            pef_pkg::FN_CLEAR: cnt_nxt = '0;
            pef_pkg::FN_LOAD: begin
              if (load_go) cnt_nxt = cnt_r + CNTW'(1);
            end
            pef_pkg::FN_TEST: begin
              state_nxt = ST_SWEEP;
              step_nxt  = '0;
              acc_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        step_nxt = step_r + IDXW'(1);
        if (step_r == IDXW'(CAPACITY - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: ;
      default: state_nxt = ST_IDLE;
    endcase
    if (tok_out.act) begin
      acc_nxt = acc_r || hit;
      if (tok_out.last) begin
        out_valid_nxt = !(acc_r || hit);
        state_nxt     = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_data.func == pef_pkg::FN_TEST)) begin
      cand_r <= in_data;
    end
    out_r <= '{out_tag: cand_r.tag, out_x: cand_r.pos_x, out_y: cand_r.pos_y,
               out_z: cand_r.pos_z};
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_one_cycle_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(CAPACITY))
    else $error("suppressor count beyond capacity");

  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.func == pef_pkg::FN_TEST) |=> busy && (step_r == '0))
    else $error("test word did not start a sweep");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a sweep is running");

endmodule
